FILE: rtl/pps_pkg.sv
package pps_pkg;

  // Sizing
  localparam int MAX_VERTS_DEF = 16;
  localparam int DW            = 52;  // signed plane distance, Q.24
  localparam int TW            = 30;  // split fraction, Q0.30
  localparam int CFG_IW        = 3;
  localparam int CFG_DW        = 32;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_NORMAL_X  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_NORMAL_Y  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_NORMAL_Z  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_PLANE_D   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_EPSILON   = 3'd4;

  // Vertex classes
  localparam logic [1:0] CLS_FRONT = 2'd0;
  localparam logic [1:0] CLS_BACK  = 2'd1;
  localparam logic [1:0] CLS_ON    = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_SPLIT       = 2'd0;
  localparam logic [1:0] ST_WHOLE_FRONT = 2'd1;
  localparam logic [1:0] ST_WHOLE_BACK  = 2'd2;
  localparam logic [1:0] ST_TOO_MANY    = 2'd3;

  // Unit normal components (+1.0 and -1.0 in Q2.16)
  localparam logic signed [17:0] UNIT_POS = 18'sh10000;
  localparam logic signed [17:0] UNIT_NEG = 18'sh30000;

  // Read address select
  localparam logic [1:0] RD_IDX  = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_ZERO = 2'd2;

  // Emit select
  localparam logic [1:0] EM_ERR   = 2'd0;
  localparam logic [1:0] EM_WHOLE = 2'd1;
  localparam logic [1:0] EM_CUR   = 2'd2;
  localparam logic [1:0] EM_SPLIT = 2'd3;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic               final_vertex;
  } vertex_t;

  typedef struct packed {
    logic               out_side;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         split_status;
    logic               run_end;
  } result_t;

  typedef struct packed {
    logic       vtx_accept;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cls_mul;
    logic       cls_sum;
    logic       cls_wr;
    logic       idx_clr;
    logic       idx_inc;
    logic       cur_load;
    logic       walk_clr;
    logic       walk_flip;
    logic       div_init;
    logic       div_step;
    logic       spl_mul;
    logic       emit;
    logic [1:0] emit_sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_final;
    logic ovf_hit;
    logic idx_last;
    logic slot_free;
    logic whole;
    logic run_err;
    logic cur_emit;
    logic need_split;
    logic div_done;
    logic walk_back;
  } dp_stat_t;

endpackage

FILE: rtl/pps_ctrl.sv
module pps_ctrl
  import pps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  localparam logic [4:0] S_LOAD    = 5'd0;
  localparam logic [4:0] S_ERR     = 5'd1;
  localparam logic [4:0] S_CL_RD   = 5'd2;
  localparam logic [4:0] S_CL_MUL  = 5'd3;
  localparam logic [4:0] S_CL_SUM  = 5'd4;
  localparam logic [4:0] S_CL_WR   = 5'd5;
  localparam logic [4:0] S_DECIDE  = 5'd6;
  localparam logic [4:0] S_WH_RD   = 5'd7;
  localparam logic [4:0] S_WH_EMIT = 5'd8;
  localparam logic [4:0] S_W_FIRST = 5'd9;
  localparam logic [4:0] S_W_CUR   = 5'd10;
  localparam logic [4:0] S_W_RD    = 5'd11;
  localparam logic [4:0] S_W_EMIT  = 5'd12;
  localparam logic [4:0] S_W_DIVI  = 5'd13;
  localparam logic [4:0] S_W_DIV   = 5'd14;
  localparam logic [4:0] S_W_MUL   = 5'd15;
  localparam logic [4:0] S_W_SPL   = 5'd16;
  localparam logic [4:0] S_W_ADV   = 5'd17;

  logic [4:0] state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.vtx_accept = 1'b1;
          if (stat.in_final) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = stat.ovf_hit ? S_ERR : S_CL_RD;
          end
        end
      end
      S_ERR: begin
        if (stat.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_ERR;
          state_nxt    = S_LOAD;
        end
      end
      S_CL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_nxt  = S_CL_MUL;
      end
      S_CL_MUL: begin
        cmd.cls_mul = 1'b1;
        state_nxt   = S_CL_SUM;
      end
      S_CL_SUM: begin
        cmd.cls_sum = 1'b1;
        state_nxt   = S_CL_WR;
      end
      S_CL_WR: begin
        cmd.cls_wr = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CL_RD;
        end
      end
      S_DECIDE: begin
        cmd.idx_clr = 1'b1;
        if (stat.whole) begin
          state_nxt = S_WH_RD;
        end else if (stat.run_err) begin
          state_nxt = S_ERR;
        end else begin
          cmd.walk_clr = 1'b1;
          state_nxt    = S_W_FIRST;
        end
      end
      S_WH_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_nxt  = S_WH_EMIT;
      end
      S_WH_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_WHOLE;
          if (stat.idx_last) begin
            state_nxt = S_LOAD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_WH_RD;
          end
        end
      end
      S_W_FIRST: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ZERO;
        state_nxt  = S_W_CUR;
      end
      S_W_CUR: begin
        cmd.cur_load = 1'b1;
        state_nxt    = S_W_RD;
      end
      S_W_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_NEXT;
        state_nxt  = S_W_EMIT;
      end
      S_W_EMIT: begin
        if (!stat.cur_emit || stat.slot_free) begin
          cmd.emit     = stat.cur_emit;
          cmd.emit_sel = EM_CUR;
          state_nxt    = stat.need_split ? S_W_DIVI : S_W_ADV;
        end
      end
      S_W_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_W_DIV;
      end
      S_W_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_W_MUL;
        end
      end
      S_W_MUL: begin
        cmd.spl_mul = 1'b1;
        state_nxt   = S_W_SPL;
      end
      S_W_SPL: begin
        if (stat.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_SPLIT;
          state_nxt    = S_W_ADV;
        end
      end
      S_W_ADV: begin
        cmd.cur_load = 1'b1;
        if (stat.idx_last) begin
          if (stat.walk_back) begin
            state_nxt = S_LOAD;
          end else begin
            cmd.walk_flip = 1'b1;
            cmd.idx_clr   = 1'b1;
            state_nxt     = S_W_FIRST;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_W_RD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

FILE: rtl/pps_dpath.sv
module pps_dpath
  import pps_pkg::*;
#(
  parameter int MAX_VERTS = MAX_VERTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  vertex_t           in_data,
  input  ctl_cmd_t          cmd,
  output dp_stat_t          stat,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           out_data
);

  localparam int AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int RW = CW + 2;

  function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] v);
    mag_d = v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  // a front/back pair crosses the plane
  function automatic logic crosses(input logic [1:0] a, input logic [1:0] b);
    crosses = (a != CLS_ON) && (b != CLS_ON) && (a != b);
  endfunction

  // Configuration registers
  logic signed [17:0] nrm_r [3];
  logic signed [31:0] pd_r;
  logic [15:0]        eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r[0] <= '0;
      nrm_r[1] <= '0;
      nrm_r[2] <= UNIT_POS;
      pd_r     <= '0;
      eps_r    <= 16'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NORMAL_X: nrm_r[0] <= cfg_wdata[17:0];
        REG_NORMAL_Y: nrm_r[1] <= cfg_wdata[17:0];
        REG_NORMAL_Z: nrm_r[2] <= cfg_wdata[17:0];
        REG_PLANE_D:  pd_r     <= cfg_wdata;
        REG_EPSILON:  eps_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Vertex fill count and overflow
  logic [CW-1:0] vcnt_r, n_r;
  logic          ovf_r;
  logic          room;

  assign room = vcnt_r < CW'(MAX_VERTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= '0;
      ovf_r  <= 1'b0;
      n_r    <= '0;
    end else if (cmd.vtx_accept) begin
      if (in_data.final_vertex) begin
        vcnt_r <= '0;
        ovf_r  <= 1'b0;
        n_r    <= room ? vcnt_r + CW'(1) : vcnt_r;
      end else if (room) begin
        vcnt_r <= vcnt_r + CW'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Walk index
  logic [AW-1:0] idx_r, rd_addr;
  logic          idx_last;

  assign idx_last = (CW'(idx_r) == n_r - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_IDX:  rd_addr = idx_r;
      RD_NEXT: rd_addr = idx_last ? '0 : idx_r + AW'(1);
      default: rd_addr = '0;
    endcase
  end

  // Vertex, distance and class memories
  logic [31:0]        mem_x [MAX_VERTS];
  logic [31:0]        mem_y [MAX_VERTS];
  logic [31:0]        mem_z [MAX_VERTS];
  logic [DW-1:0]      mem_d [MAX_VERTS];
  logic [1:0]         mem_s [MAX_VERTS];
  logic signed [31:0] rd_c_r [3];
  logic signed [DW-1:0] rd_d_r;
  logic [1:0]         rd_s_r;
  logic signed [DW-1:0] d_r;
  logic [1:0]         side_now;

  always_ff @(posedge clk) begin
    if (cmd.vtx_accept && room) begin
      mem_x[vcnt_r[AW-1:0]] <= in_data.vertex_x;
      mem_y[vcnt_r[AW-1:0]] <= in_data.vertex_y;
      mem_z[vcnt_r[AW-1:0]] <= in_data.vertex_z;
    end
    if (cmd.cls_wr) begin
      mem_d[idx_r] <= d_r;
      mem_s[idx_r] <= side_now;
    end
    if (cmd.rd_en) begin
      rd_c_r[0] <= mem_x[rd_addr];
      rd_c_r[1] <= mem_y[rd_addr];
      rd_c_r[2] <= mem_z[rd_addr];
      rd_d_r    <= mem_d[rd_addr];
      rd_s_r    <= mem_s[rd_addr];
    end
  end

  // Classification: products, then signed distance
  logic signed [49:0]   prod_r [3];
  logic signed [DW-1:0] plane_term, eps_w;

  assign plane_term = $signed({{(DW-48){pd_r[31]}}, pd_r, 16'b0});
  assign eps_w      = $signed({{(DW-32){1'b0}}, eps_r, 16'b0});

  always_ff @(posedge clk) begin
    if (cmd.cls_mul) begin
      for (int a = 0; a < 3; a++) begin
        prod_r[a] <= rd_c_r[a] * nrm_r[a];
      end
    end
    if (cmd.cls_sum) begin
      d_r <= DW'(prod_r[0]) + DW'(prod_r[1]) + DW'(prod_r[2]) - plane_term;
    end
  end

  always_comb begin
    if (d_r > eps_w) begin
      side_now = CLS_FRONT;
    end else if (d_r < -eps_w) begin
      side_now = CLS_BACK;
    end else begin
      side_now = CLS_ON;
    end
  end

  // Class counts and crossing count
  logic [CW-1:0] cnt_f_r, cnt_b_r, cnt_o_r, spl_r;
  logic [1:0]    prev_s_r, first_s_r, first_eff;
  logic          e_prev, e_wrap;

  assign first_eff = (idx_r == '0) ? side_now : first_s_r;
  assign e_prev    = (idx_r != '0) && crosses(prev_s_r, side_now);
  assign e_wrap    = idx_last && crosses(side_now, first_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_f_r <= '0;
      cnt_b_r <= '0;
      cnt_o_r <= '0;
      spl_r   <= '0;
    end else if (cmd.vtx_accept && in_data.final_vertex) begin
      cnt_f_r <= '0;
      cnt_b_r <= '0;
      cnt_o_r <= '0;
      spl_r   <= '0;
    end else if (cmd.cls_wr) begin
      unique case (side_now)
        CLS_FRONT: cnt_f_r <= cnt_f_r + CW'(1);
        CLS_BACK:  cnt_b_r <= cnt_b_r + CW'(1);
        default:   cnt_o_r <= cnt_o_r + CW'(1);
      endcase
      spl_r <= spl_r + CW'(e_prev) + CW'(e_wrap);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cls_wr) begin
      prev_s_r  <= side_now;
      first_s_r <= first_eff;
    end
  end

  // Run lengths and limit
  logic [RW-1:0] rn_f, rn_b, rn_lim;
  logic          whole_back;

  assign rn_f       = RW'(cnt_f_r) + RW'(cnt_o_r) + RW'(spl_r);
  assign rn_b       = RW'(cnt_b_r) + RW'(cnt_o_r) + RW'(spl_r);
  assign rn_lim     = RW'(n_r) + RW'(4);
  assign whole_back = (cnt_f_r == '0);

  // Current vertex of the walk
  logic signed [31:0]   cur_c_r [3];
  logic signed [DW-1:0] cur_d_r;
  logic [1:0]           cur_s_r;
  logic                 walk_side_r;
  logic [RW-1:0]        emit_cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.cur_load) begin
      for (int a = 0; a < 3; a++) begin
        cur_c_r[a] <= rd_c_r[a];
      end
      cur_d_r <= rd_d_r;
      cur_s_r <= rd_s_r;
    end
  end

  // Fraction divider, one quotient bit per cycle
  logic [DW-1:0] rem_r, den_r;
  logic [DW:0]   rem2;
  logic [TW-1:0] q_r;
  logic [4:0]    dcnt_r;

  assign rem2 = {rem_r, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r  <= mag_d(cur_d_r);
      den_r  <= mag_d(cur_d_r) + mag_d(rd_d_r);
      q_r    <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, den_r}) begin
        rem_r <= DW'(rem2 - {1'b0, den_r});
        q_r   <= {q_r[TW-2:0], 1'b1};
      end else begin
        rem_r <= rem2[DW-1:0];
        q_r   <= {q_r[TW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 5'd1;
    end
  end

  // Split point: |delta| * t per axis, registered
  logic [62:0]        pm_r [3];
  logic               neg_r [3];
  logic signed [32:0] delta [3];
  logic [32:0]        dmag [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      delta[a] = 33'(rd_c_r[a]) - 33'(cur_c_r[a]);
      dmag[a]  = delta[a][32] ? (~delta[a] + 1'b1) : delta[a];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.spl_mul) begin
      for (int a = 0; a < 3; a++) begin
        pm_r[a]  <= dmag[a] * q_r;
        neg_r[a] <= delta[a][32];
      end
    end
  end

  // Round, apply, or snap to the plane on a unit normal
  logic [63:0]        rsum [3];
  logic [33:0]        rnd [3];
  logic [33:0]        cur_w [3];
  logic signed [31:0] spl_c [3];
  logic signed [31:0] pd_neg;

  assign pd_neg = (pd_r == 32'sh80000000) ? 32'sh7fffffff : -pd_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rsum[a]  = {1'b0, pm_r[a]} + 64'(1 << 29);
      rnd[a]   = rsum[a][63:30];
      cur_w[a] = 34'(cur_c_r[a]);
      if (nrm_r[a] == UNIT_POS) begin
        spl_c[a] = pd_r;
      end else if (nrm_r[a] == UNIT_NEG) begin
        spl_c[a] = pd_neg;
      end else if (neg_r[a]) begin
        spl_c[a] = 32'(cur_w[a] - rnd[a]);
      end else begin
        spl_c[a] = 32'(cur_w[a] + rnd[a]);
      end
    end
  end

  // Walk side and emit count
  logic walk_end;

  assign walk_end = walk_side_r && ((emit_cnt_r + RW'(1)) == rn_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_side_r <= 1'b0;
      emit_cnt_r  <= '0;
    end else if (cmd.walk_clr) begin
      walk_side_r <= 1'b0;
      emit_cnt_r  <= '0;
    end else if (cmd.walk_flip) begin
      walk_side_r <= 1'b1;
      emit_cnt_r  <= '0;
    end else if (cmd.emit && (cmd.emit_sel == EM_CUR || cmd.emit_sel == EM_SPLIT)) begin
      emit_cnt_r <= emit_cnt_r + RW'(1);
    end
  end

  // Result mux
  result_t res;

  always_comb begin
    res = '0;
    unique case (cmd.emit_sel)
      EM_ERR: begin
        res.split_status = ST_TOO_MANY;
        res.run_end      = 1'b1;
      end
      EM_WHOLE: begin
        res.out_side     = whole_back;
        res.out_x        = rd_c_r[0];
        res.out_y        = rd_c_r[1];
        res.out_z        = rd_c_r[2];
        res.split_status = whole_back ? ST_WHOLE_BACK : ST_WHOLE_FRONT;
        res.run_end      = idx_last;
      end
      EM_CUR: begin
        res.out_side     = walk_side_r;
        res.out_x        = cur_c_r[0];
        res.out_y        = cur_c_r[1];
        res.out_z        = cur_c_r[2];
        res.split_status = ST_SPLIT;
        res.run_end      = walk_end;
      end
      default: begin
        res.out_side     = walk_side_r;
        res.out_x        = spl_c[0];
        res.out_y        = spl_c[1];
        res.out_z        = spl_c[2];
        res.split_status = ST_SPLIT;
        res.run_end      = walk_end;
      end
    endcase
  end

  // Output register
  logic    out_valid_r;
  result_t out_data_r;
  logic    slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status to the controller
  always_comb begin
    stat.in_final   = in_data.final_vertex;
    stat.ovf_hit    = ovf_r || !room;
    stat.idx_last   = idx_last;
    stat.slot_free  = slot_free;
    stat.whole      = (cnt_f_r == '0) || (cnt_b_r == '0);
    stat.run_err    = (rn_f > rn_lim) || (rn_b > rn_lim);
    stat.cur_emit   = (cur_s_r == {1'b0, walk_side_r}) || (cur_s_r == CLS_ON);
    stat.need_split = crosses(cur_s_r, rd_s_r);
    stat.div_done   = (dcnt_r == 5'(TW - 1));
    stat.walk_back  = walk_side_r;
  end

endmodule

FILE: rtl/polygon_plane_split_unit.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready  | vertex_t: one vertex, final flag
// out_    | output    | out_valid / out_ready| result_t: one point of a run
// cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// Vertices load at one per cycle; in_ready then stays low after the final vertex
// until the last result is issued. Each vertex is classified (memory read,
// products, sum, store). A whole polygon is then read out one result at a time.
// A split polygon is walked twice (front, back), each edge a read, an emit and an
// advance, plus the 30-step divider and the split multiply per crossing edge per
// walk. Synchronous reset returns configuration to defaults; the vertex store
// needs no clearing. A stalled out_ready holds the walk in place.
module polygon_plane_split_unit
  import pps_pkg::*;
#(
  parameter int MAX_VERTS = MAX_VERTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vertex_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pps_dpath #(
    .MAX_VERTS (MAX_VERTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Error result is a lone closing record on the front side
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.split_status == ST_TOO_MANY)
      |-> out_data.run_end && !out_data.out_side)
    else $error("error result not a lone closing record");

  // Whole-polygon status agrees with the side
  a_whole_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.split_status == ST_WHOLE_FRONT) |-> !out_data.out_side)
    else $error("wholly front result on back side");

  a_whole_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.split_status == ST_WHOLE_BACK) |-> out_data.out_side)
    else $error("wholly back result on front side");

  // A split polygon closes on the back run
  a_split_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.split_status == ST_SPLIT) && out_data.run_end
      |-> out_data.out_side)
    else $error("split polygon closed on front run");

endmodule
